[src/hbd_pkg.sv]
// Shared types, constants and a helper function for the Huffman tree bit decoder.
package hbd_pkg;

  localparam int NODE_W      = 9;
  localparam int LINK_W      = 10;
  localparam int SYM_W       = 8;
  localparam int CHILD_DEPTH = 1024;
  localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
  localparam int MAX_SYMBOLS = 256;
  localparam int SYM_AW      = $clog2(MAX_SYMBOLS);
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [SYM_W-1:0]  sym_t;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_DECODE = 1'b1
  } func_t;

  typedef enum logic {
    REG_LEAF_COUNT = 1'b0,
    REG_NONE       = 1'b1
  } reg_index_t;

  localparam node_t MAX_SYMBOLS_NODE = node_t'(MAX_SYMBOLS);

  // A node is a leaf when it lies in 1..min(leaf_count, MAX_SYMBOLS).
  function automatic logic is_leaf(input node_t node, input node_t leaf_count);
    node_t limit;
    limit = (leaf_count > MAX_SYMBOLS_NODE) ? MAX_SYMBOLS_NODE : leaf_count;
    return (node != '0) && (node <= limit);
  endfunction

endpackage

[src/huffman_tree_bit_decoder.sv]
// Huffman tree bit decoder: tree load, bit walk, and output queue.
// A code bit reaching a leaf: child read, symbol read, queue write, then out_valid rises.
// Throughput: one transaction per cycle; the child table read result is forwarded
// straight into the next read address. in_ready drops only while queued symbols and
// in-flight code bits fill the four-entry output queue.
// Reset clears control state, sets leaf_count to 256 and puts the walk at the root.
module huffman_tree_bit_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hbd_pkg::APB_AW-1:0]    paddr,
  input  logic [hbd_pkg::APB_DW-1:0]    pwdata,
  output logic [hbd_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [hbd_pkg::NODE_W-1:0]    node_index,
  input  logic signed [hbd_pkg::LINK_W-1:0] parent_link,
  input  logic [hbd_pkg::SYM_W-1:0]     leaf_symbol,
  input  logic                          code_bit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hbd_pkg::SYM_W-1:0]     symbol
);

  import hbd_pkg::*;

  // Configuration.
  node_t      leaf_count;
  reg_index_t reg_sel;
  logic       cfg_write;

  // Pipeline control.
  logic       in_fire;
  logic       is_load;
  logic       is_decode;
  logic       b_valid;
  logic       c_valid;
  node_t      root_node;
  node_t      walk_node;
  node_t      walk_node_next;
  node_t      walk_eff;
  node_t      cur_node;
  node_t      next_node;
  logic       next_leaf;

  // Load decoding.
  logic                link_neg;
  node_t               link_mag;
  logic                root_load;
  logic [CHILD_AW-1:0] load_addr;

  // Memories.
  logic [CHILD_AW-1:0] child_raddr;
  node_t               child_rdata_w;
  logic                child_we;
  logic                sym_we;
  logic [SYM_AW-1:0]   sym_waddr;
  logic [SYM_AW-1:0]   sym_raddr;
  sym_t                sym_rdata;
  node_t               leaf_minus_one;
  node_t               node_minus_one;

  // Output queue.
  sym_t                fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr;
  logic [FIFO_AW-1:0]  rd_ptr;
  logic [FIFO_CW-1:0]  fifo_count;
  logic [FIFO_CW-1:0]  credit;
  logic                out_fire;

  // APB register access.
  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[APB_AW-1]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_LEAF_COUNT: prdata = {{(APB_DW-NODE_W){1'b0}}, leaf_count};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= MAX_SYMBOLS_NODE;
    end else if (cfg_write && (reg_sel == REG_LEAF_COUNT)) begin
      leaf_count <= pwdata[NODE_W-1:0];
    end
  end

  // Every accepted decode transaction reserves queue room for a possible symbol.
  assign credit    = fifo_count + FIFO_CW'(b_valid) + FIFO_CW'(c_valid);
  assign in_ready  = (credit < FIFO_CW'(FIFO_DEPTH));
  assign in_fire   = in_valid && in_ready;
  assign is_load   = in_fire && (func_t'(func) == FUNC_LOAD);
  assign is_decode = in_fire && (func_t'(func) == FUNC_DECODE);

  // Decode of the parent link.
  assign link_neg  = parent_link[LINK_W-1];
  assign link_mag  = link_neg ? node_t'(-parent_link) : parent_link[NODE_W-1:0];
  assign root_load = !link_neg && (parent_link[NODE_W-1:0] == node_index);
  assign load_addr = {link_mag, !link_neg};
  assign child_we  = is_load && !root_load;

  assign node_minus_one = node_index - node_t'(1);
  assign sym_we         = is_load && is_leaf(node_index, leaf_count);
  assign sym_waddr      = node_minus_one[SYM_AW-1:0];

  // Walk step: the child read issued last cycle resolves the position now.
  assign next_node      = child_rdata_w;
  assign next_leaf      = is_leaf(next_node, leaf_count);
  assign walk_node_next = next_leaf ? '0 : next_node;
  assign walk_eff       = b_valid ? walk_node_next : walk_node;
  assign cur_node       = (walk_eff == '0) ? root_node : walk_eff;
  assign child_raddr    = is_decode ? {cur_node, code_bit} : load_addr;

  assign leaf_minus_one = next_node - node_t'(1);
  assign sym_raddr      = leaf_minus_one[SYM_AW-1:0];

  hbd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (CHILD_DEPTH)
  ) u_child_ram (
    .clk   (clk),
    .we    (child_we),
    .waddr (load_addr),
    .wdata (node_index),
    .raddr (child_raddr),
    .rdata (child_rdata_w)
  );

  hbd_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_SYMBOLS)
  ) u_sym_ram (
    .clk   (clk),
    .we    (sym_we),
    .waddr (sym_waddr),
    .wdata (leaf_symbol),
    .raddr (sym_raddr),
    .rdata (sym_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      root_node <= '0;
      walk_node <= '0;
    end else begin
      b_valid <= is_decode;
      c_valid <= b_valid && next_leaf;
      if (b_valid) begin
        walk_node <= walk_node_next;
      end
      if (is_load && root_load) begin
        root_node <= node_index;
      end
    end
  end

  // Output queue between the symbol read and the result channel.
  assign out_valid = (fifo_count != '0);
  assign out_fire  = out_valid && out_ready;
  assign symbol    = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (c_valid) begin
      fifo_mem[wr_ptr] <= sym_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (c_valid) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_count <= fifo_count + FIFO_CW'(c_valid) - FIFO_CW'(out_fire);
    end
  end

endmodule

[src/hbd_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module hbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read and a write to the same entry in one cycle return the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
